// ===== hdl/psq_pkg.sv =====
// Package for the positional sequence store: widths, operation and status
// codes, and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

	// Field widths and default store capacity.
	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int MODE_W       = 3;
	localparam int STAT_W       = 2;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ERASE_F = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ERASE_B = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP    = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the incoming request
		logic apply;      // carry out the latched operation if it is legal
		logic load_sum;   // load a single summary result
		logic load_elem;  // load the front element and rotate the cell row
	} psq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dump_go;    // latched request is a dump of a non-empty store
		logic dump_last;  // the element now at the front is the final one
	} psq_sts_t;

endpackage

`default_nettype wire

// ===== hdl/psq_in_if.sv =====
// Request channel of the positional sequence store: handshake and payload.
// Depends on psq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psq_in_if
	import psq_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/psq_out_if.sv =====
// Result channel of the positional sequence store: handshake and payload.
// Depends on psq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psq_out_if
	import psq_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	logic                     has_element;
	logic [STAT_W-1:0]        status;
	logic                     last;

	modport source (output valid, output element, output has_element, output status,
		output last, input ready);
	modport sink   (input valid, input element, input has_element, input status,
		input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/positional_sequence_store_top.sv =====
// Top level of the positional sequence store: controller plus datapath.
// Depends on psq_pkg, psq_in_if, psq_out_if, psq_ctrl and psq_dp.
//
//   Channel  Direction  Carries
//   req      in         mode, position, value
//   rsp      out        element, has_element, status, last
//
// Append, insert, erase and illegal requests go through transfer, then execute,
// where a legal change shifts the cell row by one place and the result is loaded.
// After execute, a dump rotates the cell row one element a cycle into the result
// register while that register is free. Reset clears the length and the control state;
// the cells need no clearing. A stalled result sink holds the sequencer, while
// one finished result may wait as the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module positional_sequence_store_top
	import psq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psq_in_if.sink     req,
	psq_out_if.source  rsp
);

	psq_cmd_t cmd;
	psq_sts_t sts;

	// Sequencing and handshakes.
	psq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and result payload.
	psq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (req.mode),
		.position    (req.position),
		.value       (req.value),
		.cmd         (cmd),
		.sts         (sts),
		.element     (rsp.element),
		.has_element (rsp.has_element),
		.status      (rsp.status),
		.last        (rsp.last)
	);

endmodule

`default_nettype wire

// ===== hdl/psq_dp.sv =====
// Datapath of the positional sequence store: request registers, the row of
// element cells with neighbor shifts, the length, and the result payload.
// Depends on psq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psq_dp
	import psq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [MODE_W-1:0]        mode,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire psq_cmd_t                 cmd,
	output psq_sts_t                      sts,
	output logic signed [DATA_W-1:0]      element,
	output logic                          has_element,
	output logic [STAT_W-1:0]             status,
	output logic                          last
);

	localparam int LEN_W = $clog2(CAPACITY + 1);

	logic [MODE_W-1:0]        mode_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] value_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         cnt_q;
	logic [DATA_W-1:0]        cell_q [CAPACITY];
	logic [DATA_W-1:0]        cell_d [CAPACITY];

	logic                     full;
	logic                     empty;
	logic                     pos_bad;
	logic [STAT_W-1:0]        st_code;
	logic                     op_ok;
	logic                     do_ins;
	logic                     do_del;
	logic                     do_rot;
	logic [LEN_W-1:0]         pos_t;
	logic [LEN_W-1:0]         ins_idx;
	logic [LEN_W-1:0]         del_idx;

	// Latch the request on transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			pos_q   <= position;
			value_q <= value;
		end
	end

	// Legality checks against the current length.
	assign full    = (len_q == LEN_W'(CAPACITY));
	assign empty   = (len_q == '0);
	assign pos_bad = (pos_q == '0) || (pos_q > POS_W'(len_q));
	assign pos_t   = pos_q[LEN_W-1:0];

	always_comb begin
		unique case (mode_q)
			MODE_APPEND:  st_code = full ? ST_FULL : ST_OK;
			MODE_INSERT:  st_code = full ? ST_FULL : (pos_bad ? ST_RANGE : ST_OK);
			MODE_ERASE_F,
			MODE_ERASE_B: st_code = empty ? ST_EMPTY : (pos_bad ? ST_RANGE : ST_OK);
			MODE_DUMP:    st_code = empty ? ST_EMPTY : ST_OK;
			default:      st_code = ST_RANGE;
		endcase
	end

	assign op_ok  = (st_code == ST_OK);
	assign do_ins = cmd.apply && op_ok && (mode_q == MODE_APPEND || mode_q == MODE_INSERT);
	assign do_del = cmd.apply && op_ok && (mode_q == MODE_ERASE_F || mode_q == MODE_ERASE_B);
	assign do_rot = cmd.load_elem;

	// An append is an insert at the end; an insert puts the value after
	// the given element, i.e. at zero-based index equal to the position.
	assign ins_idx = (mode_q == MODE_APPEND) ? len_q : pos_t;
	assign del_idx = (mode_q == MODE_ERASE_F) ? (pos_t - LEN_W'(1)) : (len_q - pos_t);

	// Each cell takes its own value, its lower neighbor, its upper neighbor,
	// the new value or the front cell (rotation during a dump).
	always_comb begin
		for (int j = 0; j < CAPACITY; j++) begin
			cell_d[j] = cell_q[j];
			if (do_ins) begin
				if (LEN_W'(j) > ins_idx)
					cell_d[j] = cell_q[(j > 0) ? j - 1 : 0];
				else if (LEN_W'(j) == ins_idx)
					cell_d[j] = value_q;
			end else if (do_del) begin
				if (LEN_W'(j) >= del_idx)
					cell_d[j] = cell_q[(j + 1 < CAPACITY) ? j + 1 : j];
			end else if (do_rot) begin
				if (LEN_W'(j + 1) == len_q)
					cell_d[j] = cell_q[0];
				else if (LEN_W'(j) < len_q)
					cell_d[j] = cell_q[(j + 1 < CAPACITY) ? j + 1 : j];
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	// Length and dump counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_ins)
				len_q <= len_q + LEN_W'(1);
			else if (do_del)
				len_q <= len_q - LEN_W'(1);
			if (cmd.capture)
				cnt_q <= '0;
			else if (do_rot)
				cnt_q <= cnt_q + LEN_W'(1);
		end
	end

	assign sts.dump_go   = (mode_q == MODE_DUMP) && !empty;
	assign sts.dump_last = (cnt_q == len_q - LEN_W'(1));

	// Result payload register.
	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			element     <= '0;
			has_element <= 1'b0;
			status      <= st_code;
			last        <= 1'b1;
		end else if (cmd.load_elem) begin
			element     <= cell_q[0];
			has_element <= 1'b1;
			status      <= ST_OK;
			last        <= sts.dump_last;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/psq_ctrl.sv =====
// Controller of the positional sequence store: request handshake, execute
// and dump sequencing, and the result valid flag. Depends on psq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psq_ctrl
	import psq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	input  wire psq_sts_t sts,
	output psq_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_free;
	logic       load;

	// The result register can take a new result when empty or being drained.
	assign out_free  = !rsp_valid || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign load      = cmd.load_sum || cmd.load_elem;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.dump_go) begin
					state_d = S_DUMP;
				end else if (out_free) begin
					cmd.apply    = 1'b1;
					cmd.load_sum = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					cmd.load_elem = 1'b1;
					if (sts.dump_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
		end
	end

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !load)
		else $error("result overwritten while stalled");

	// A request transfer is always followed by the execute step.
	a_exec_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_EXEC))
		else $error("execute step missing after request");

	// The final dump element returns the controller to idle.
	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && cmd.load_elem && sts.dump_last) |=> (state_q == S_IDLE))
		else $error("dump did not end on its final element");

	// Modifications happen only in the execute step.
	a_apply_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> (state_q == S_EXEC && !sts.dump_go))
		else $error("operation applied outside the execute step");

endmodule

`default_nettype wire

// ===== dv/positional_sequence_store_top_tb.sv =====
// Self-checking testbench for positional_sequence_store_top: directed table, then random traffic.
// Depends on psq_pkg, psq_in_if, psq_out_if and the top level with its submodules.
// Results are checked field by field against a queue-based model of the sequence.
`timescale 1ns / 1ps

module positional_sequence_store_top_tb;
	import psq_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int RAND_ITEMS   = 500;
	localparam int MAX_IDLE     = 18;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int REPORT_MAX   = 10;

	// One result as it appears on the response channel.
	typedef struct packed {
		logic [DATA_W-1:0] element;
		logic              has_element;
		logic [STAT_W-1:0] status;
		logic              last;
	} rsp_t;

	// One row of the directed table; typed rows carry their own expected status.
	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] value;
		bit                typed;
		logic [STAT_W-1:0] status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	psq_in_if  req_if();
	psq_out_if rsp_if();

	positional_sequence_store_top #(
		.CAPACITY(CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Model of the stored sequence and the results still owed by the block.
	logic [DATA_W-1:0] seq_model[$];
	rsp_t              expected_rsp[$];

	int  mismatches;
	int  item_count;
	int  dump_count;
	int  result_count;
	int  peak_len;
	int  status_seen[4];
	bit  src_calm;
	bit  sink_calm;
	int  sink_hold;
	int  sink_draw;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the sequence model and, if asked, queue the results it causes.
	function automatic void track_sequence(input logic [MODE_W-1:0] m,
			input logic [POS_W-1:0] p, input logic [DATA_W-1:0] v, input bit record);
		int   len;
		rsp_t r;
		len = seq_model.size();
		r = '{element: '0, has_element: 1'b0, status: ST_OK, last: 1'b1};
		case (m)
			MODE_APPEND: begin
				if (len >= CAP)
					r.status = ST_FULL;
				else
					seq_model.push_back(v);
			end
			MODE_INSERT: begin
				// Fullness is checked before the position.
				if (len >= CAP)
					r.status = ST_FULL;
				else if (p < 1 || p > len)
					r.status = ST_RANGE;
				else if (p == len)
					seq_model.push_back(v);
				else
					seq_model.insert(p, v);
			end
			MODE_ERASE_F: begin
				if (len == 0)
					r.status = ST_EMPTY;
				else if (p < 1 || p > len)
					r.status = ST_RANGE;
				else
					seq_model.delete(p - 1);
			end
			MODE_ERASE_B: begin
				if (len == 0)
					r.status = ST_EMPTY;
				else if (p < 1 || p > len)
					r.status = ST_RANGE;
				else
					seq_model.delete(len - p);
			end
			MODE_DUMP: begin
				dump_count++;
				if (len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// A dump of a non-empty store streams every element in order.
					status_seen[ST_OK]++;
					for (int i = 0; i < len; i++) begin
						r = '{element: seq_model[i], has_element: 1'b1, status: ST_OK,
							last: (i == len - 1)};
						if (record)
							expected_rsp.push_back(r);
					end
					return;
				end
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		status_seen[r.status]++;
		if (seq_model.size() > peak_len)
			peak_len = seq_model.size();
		if (record)
			expected_rsp.push_back(r);
	endfunction

	function automatic stim_row_t make_row(input logic [MODE_W-1:0] m,
			input logic [POS_W-1:0] p, input logic [DATA_W-1:0] v, input bit typed,
			input logic [STAT_W-1:0] st);
		stim_row_t row_v;
		row_v = '{mode: m, position: p, value: v, typed: typed, status: st};
		return row_v;
	endfunction

	// Present one request after a random gap and wait for its transfer.
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
			input logic [DATA_W-1:0] v, input bit typed, input logic [STAT_W-1:0] st);
		int   gap;
		rsp_t r;
		gap = src_calm ? 0 : $urandom_range(0, MAX_IDLE);
		if ($urandom_range(0, 24) == 0)
			src_calm = !src_calm;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.mode     <= m;
		req_if.position <= p;
		req_if.value    <= v;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		// Transfer taken at this edge: predict now, before the result can appear.
		item_count++;
		track_sequence(m, p, v, !typed);
		if (typed) begin
			r = '{element: '0, has_element: 1'b0, status: st, last: 1'b1};
			expected_rsp.push_back(r);
		end
	endtask

	// Result sink: random stall before each result, with stretches of none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			sink_hold    <= 0;
			sink_calm    = 1'b0;
			sink_draw    = 0;
		end else if (rsp_if.valid && rsp_if.ready) begin
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
			sink_draw = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (sink_draw > 0) begin
				rsp_if.ready <= 1'b0;
				sink_hold    <= sink_draw;
			end
		end else if (sink_hold > 1) begin
			sink_hold <= sink_hold - 1;
		end else begin
			sink_hold    <= 0;
			rsp_if.ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			result_count++;
			got = '{element: rsp_if.element, has_element: rsp_if.has_element,
				status: rsp_if.status, last: rsp_if.last};
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result element=%0d has=%0b status=%0d last=%0b",
						$realtime, $signed(got.element), got.has_element, got.status, got.last);
			end else begin
				want = expected_rsp.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result mismatch, expected element=%0d has=%0b status=%0d",
							$realtime, $signed(want.element), want.has_element, want.status,
							" last=%0b, got element=%0d has=%0b status=%0d last=%0b",
							want.last, $signed(got.element), got.has_element, got.status,
							got.last);
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// Stimulus: reset, directed table, then growth and shrink phases of random traffic.
	initial begin : stimulus
		stim_row_t         dir_rows[$];
		logic [MODE_W-1:0] m;
		logic [POS_W-1:0]  p;
		logic [DATA_W-1:0] v;
		int                len;
		int                r;
		int                extreme_hits;
		bit                grow;

		mismatches   = 0;
		item_count   = 0;
		dump_count   = 0;
		result_count = 0;
		peak_len     = 0;
		status_seen  = '{default: 0};
		src_calm     = 1'b0;
		arst_n       = 1'b0;
		req_if.valid    <= 1'b0;
		req_if.mode     <= MODE_APPEND;
		req_if.position <= '0;
		req_if.value    <= '0;

		// Empty store: every erase and dump reports empty, any insert is out of range.
		dir_rows.push_back(make_row(MODE_DUMP,    7'd0,   32'h0, 1, ST_EMPTY));
		dir_rows.push_back(make_row(MODE_ERASE_F, 7'd1,   32'h0, 1, ST_EMPTY));
		dir_rows.push_back(make_row(MODE_ERASE_B, 7'd0,   32'h0, 1, ST_EMPTY));
		dir_rows.push_back(make_row(MODE_INSERT,  7'd1,   32'h1, 1, ST_RANGE));
		// Appends of the value extremes.
		dir_rows.push_back(make_row(MODE_APPEND,  7'd0,   32'h8000_0000, 1, ST_OK));
		dir_rows.push_back(make_row(MODE_APPEND,  7'd127, 32'h7FFF_FFFF, 1, ST_OK));
		dir_rows.push_back(make_row(MODE_APPEND,  7'd0,   32'h0000_0000, 1, ST_OK));
		dir_rows.push_back(make_row(MODE_APPEND,  7'd64,  32'hFFFF_FFFF, 1, ST_OK));
		// Insert positions just outside the legal range, then at both ends of it.
		dir_rows.push_back(make_row(MODE_INSERT,  7'd0,   32'h1234_5678, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_INSERT,  7'd5,   32'h1234_5678, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_INSERT,  7'd4,   32'h5555_5555, 0, ST_OK));
		dir_rows.push_back(make_row(MODE_INSERT,  7'd1,   32'hAAAA_AAAA, 0, ST_OK));
		dir_rows.push_back(make_row(MODE_DUMP,    7'd0,   32'h0, 0, ST_OK));
		// Erase positions out of range, then legal ones from both ends.
		dir_rows.push_back(make_row(MODE_ERASE_F, 7'd0,   32'h0, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_ERASE_F, 7'd7,   32'h0, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_ERASE_B, 7'd127, 32'h0, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_ERASE_F, 7'd1,   32'h0, 0, ST_OK));
		dir_rows.push_back(make_row(MODE_ERASE_B, 7'd1,   32'h0, 0, ST_OK));
		dir_rows.push_back(make_row(MODE_ERASE_B, 7'd4,   32'h0, 0, ST_OK));
		// Unused mode codes are rejected as out of range.
		dir_rows.push_back(make_row(3'd5,         7'd1,   32'hFFFF_FFFF, 1, ST_RANGE));
		dir_rows.push_back(make_row(3'd6,         7'd64,  32'h0, 1, ST_RANGE));
		dir_rows.push_back(make_row(3'd7,         7'd127, 32'h8000_0000, 1, ST_RANGE));
		dir_rows.push_back(make_row(MODE_DUMP,    7'd0,   32'h0, 0, ST_OK));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].mode, dir_rows[i].position, dir_rows[i].value,
				dir_rows[i].typed, dir_rows[i].status);

		// Random part: grow to capacity, stay there briefly, then shrink to empty, and so on.
		grow         = 1'b1;
		extreme_hits = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			len = seq_model.size();
			if ((grow && len == CAP) || (!grow && len == 0))
				extreme_hits++;
			if (extreme_hits > 4) begin
				// Hold the sender until the block has delivered everything owed.
				grow         = !grow;
				extreme_hits = 0;
				req_if.valid <= 1'b0;
				do
					@(posedge clk);
				while (expected_rsp.size() != 0);
			end

			r = $urandom_range(0, 99);
			v = $urandom;
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			p = (len == 0) ? 7'd1 : 7'($urandom_range(1, len));
			if ($urandom_range(0, 15) == 0)
				p = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(len + 1, 127));

			if (r < 8) begin
				m = MODE_DUMP;
			end else if (r < 12) begin
				m = 3'($urandom_range(0, 7));
				p = 7'($urandom_range(0, 127));
			end else if (grow ? (r < 82) : (r < 30)) begin
				m = r[0] ? MODE_APPEND : MODE_INSERT;
			end else begin
				m = r[0] ? MODE_ERASE_F : MODE_ERASE_B;
			end
			send_request(m, p, v, 1'b0, ST_OK);
		end

		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests with %0d dumps and %0d results; peak length %0d of %0d.",
			item_count, dump_count, result_count, peak_len, CAP);
		$display("Request outcomes: %0d ok, %0d out of range, %0d full, %0d empty; %0d mismatches.",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
			status_seen[ST_EMPTY], mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
